// ===== src/six_channel_interval_timer_defines.svh =====
// ---------------------------------------------------------------------------
// Six channel interval timer assertion macros
// Shared concurrent assertion forms used by the timer RTL.
// ---------------------------------------------------------------------------
`ifndef SIX_CHANNEL_INTERVAL_TIMER_DEFINES_SVH
`define SIX_CHANNEL_INTERVAL_TIMER_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define SCIT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define SCIT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/scit_pkg.sv =====
// ---------------------------------------------------------------------------
// Six channel interval timer package
// Request codes and the control bundle sent to each timer channel.
// ---------------------------------------------------------------------------
package scit_pkg;

   // Request type codes carried on the request channel.
   localparam logic REQ_POLL = 1'b0;
   localparam logic REQ_SET  = 1'b1;

   // Per-channel strobes for the cycle in which a request is executed.
   typedef struct packed {
      logic set_en;
      logic poll_en;
   } scit_chan_ctrl_type;

endpackage

// ===== src/scit_channel.sv =====
// ---------------------------------------------------------------------------
// Interval timer channel
// Holds start time, period and mode of one channel and checks expiry.
// ---------------------------------------------------------------------------
module scit_channel #(
   parameter int TIME_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  scit_pkg::scit_chan_ctrl_type   ctrl,
   input  logic [TIME_BITS-1:0]           period,
   input  logic                           one_shot,
   input  logic [TIME_BITS-1:0]           now,
   output logic                           fired
);
   import scit_pkg::*;

   logic [TIME_BITS-1:0] start_ff;
   logic [TIME_BITS-1:0] start_in;
   logic [TIME_BITS-1:0] interval_ff;
   logic [TIME_BITS-1:0] interval_in;
   logic                 single_ff;
   logic                 single_in;
   logic [TIME_BITS-1:0] deadline;
   logic                 expired;

   // The deadline wraps at the time width, exactly like the time input itself.
   assign deadline = start_ff + interval_ff;
   assign expired  = (interval_ff != '0) && (now > deadline);
   assign fired    = ctrl.poll_en && expired;

   always_comb begin
      start_in    = start_ff;
      interval_in = interval_ff;
      single_in   = single_ff;
      if (ctrl.set_en) begin
         start_in    = now;
         interval_in = period;
         single_in   = one_shot;
      end else if (fired) begin
         if (single_ff) begin
            interval_in = '0;
         end else begin
            start_in = now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= '0;
         interval_ff <= '0;
         single_ff   <= 1'b0;
      end else begin
         start_ff    <= start_in;
         interval_ff <= interval_in;
         single_ff   <= single_in;
      end
   end

endmodule

// ===== src/six_channel_interval_timer.sv =====
// ---------------------------------------------------------------------------
// Six channel interval timer
// Bank of one-shot or periodic interval timers polled with the current time.
// ---------------------------------------------------------------------------
//  Port group   Direction  Contents
//  req_*        in         request: poll with time, or set one channel
//  rsp_*        out        mask of the channels that fired on a poll
//
// One transaction is accepted every clock unless both registers are full and the
// response is stalled; its response is held in the response register until taken.
// All channels are checked in parallel while the request sits in the request
// register, and the mask is captured in the response register when it advances.
// Reset clears every channel to disabled, periodic, start time zero.
// A stalled response holds the request register; requests stop only when both
// registers are full and the response is stalled.
// ---------------------------------------------------------------------------
`include "six_channel_interval_timer_defines.svh"

module six_channel_interval_timer #(
   parameter int CHANNELS  = 6,
   parameter int TIME_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [2:0]          req_channel,
   input  logic [31:0]         req_period,
   input  logic                req_one_shot,
   input  logic [31:0]         req_now,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CHANNELS-1:0] rsp_fired_mask
);
   import scit_pkg::*;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s1_type_ff;
   logic [2:0]           s1_channel_ff;
   logic [31:0]          s1_period_ff;
   logic                 s1_one_shot_ff;
   logic [31:0]          s1_now_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [CHANNELS-1:0]  mask_ff;
   logic                 advance;
   logic [TIME_BITS-1:0] period_t;
   logic [TIME_BITS-1:0] now_t;
   logic [CHANNELS-1:0]  fired;
   scit_chan_ctrl_type   ctrl [CHANNELS];

   // A request executes when the response register is empty or being drained.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   assign period_t = TIME_BITS'(s1_period_ff);
   assign now_t    = TIME_BITS'(s1_now_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_type_ff     <= req_type;
         s1_channel_ff  <= req_channel;
         s1_period_ff   <= req_period;
         s1_one_shot_ff <= req_one_shot;
         s1_now_ff      <= req_now;
      end
      if (advance) begin
         mask_ff <= fired;
      end
   end

   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      // A channel number with no matching timer selects nothing.
      assign ctrl[i].set_en  = advance && (s1_type_ff == REQ_SET)
                               && (5'(s1_channel_ff) == 5'(i));
      assign ctrl[i].poll_en = advance && (s1_type_ff == REQ_POLL);

      scit_channel #(
         .TIME_BITS (TIME_BITS)
      ) u_channel (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl[i]),
         .period   (period_t),
         .one_shot (s1_one_shot_ff),
         .now      (now_t),
         .fired    (fired[i])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired_mask = mask_ff;

   `SCIT_ASSERT_NEXT(a_set_zero_mask, clock, reset,
      advance && (s1_type_ff == REQ_SET), mask_ff == '0,
      "set transaction produced a nonzero fired mask")
   `SCIT_ASSERT_SAME(a_full_blocks, clock, reset,
      s1_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready,
      "request accepted while both stages were full and stalled")
   `SCIT_ASSERT_NEXT(a_accept_loads, clock, reset,
      req_valid && req_ready, s1_valid_ff,
      "accepted request did not reach the request register")

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// Six channel interval timer testbench
// Drives set and poll requests through the request channel with bursty
// traffic, predicts each fired mask from a local copy of the channel state,
// and compares every response in order. The response side stalls on its own
// pattern, with one long hold-off that backs the block up into its input.
// ---------------------------------------------------------------------------
module testbench;
   import scit_pkg::*;

   localparam int NUM_CHANNELS = 6;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_type;
   logic [2:0]              req_channel;
   logic [31:0]             req_period;
   logic                    req_one_shot;
   logic [31:0]             req_now;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [NUM_CHANNELS-1:0] rsp_fired_mask;

   // Local copy of the channel state.
   logic [31:0] chan_start  [NUM_CHANNELS];
   logic [31:0] chan_period [NUM_CHANNELS];
   logic        chan_once   [NUM_CHANNELS];

   logic [NUM_CHANNELS-1:0] expected_masks[$];
   int error_count;
   int burst_left;
   bit sender_gapless;
   bit rx_free;
   int hold_left;

   six_channel_interval_timer uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_channel    (req_channel),
      .req_period     (req_period),
      .req_one_shot   (req_one_shot),
      .req_now        (req_now),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_fired_mask (rsp_fired_mask)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Applies one request to the local channel state and returns the mask
   // that the block should answer with.
   function automatic logic [NUM_CHANNELS-1:0] predict_fired(
      input logic        kind,
      input logic [2:0]  ch,
      input logic [31:0] per,
      input logic        once,
      input logic [31:0] stamp
   );
      logic [NUM_CHANNELS-1:0] mask;
      logic [31:0]             deadline;
      int                      i;
      mask = '0;
      if (kind == REQ_SET) begin
         if (ch < NUM_CHANNELS) begin
            chan_period[ch] = per;
            chan_once[ch]   = once;
            chan_start[ch]  = stamp;
         end
      end else begin
         for (i = 0; i < NUM_CHANNELS; i++) begin
            deadline = chan_start[i] + chan_period[i];
            if (chan_period[i] != 32'd0 && stamp > deadline) begin
               if (chan_once[i])
                  chan_period[i] = 32'd0;
               else
                  chan_start[i] = stamp;
               mask[i] = 1'b1;
            end
         end
      end
      return mask;
   endfunction

   // Prediction on each accepted request, comparison on each accepted
   // response. A response never belongs to the request taken at the same edge.
   always @(posedge clock) begin
      logic [NUM_CHANNELS-1:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_masks.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("response with no request pending: fired_mask %h",
                           rsp_fired_mask);
            end else begin
               want = expected_masks.pop_front();
               if (rsp_fired_mask !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("fired_mask mismatch: expected %h actual %h",
                              want, rsp_fired_mask);
               end
            end
         end
         if (req_valid && req_ready)
            expected_masks.push_back(predict_fired(req_type, req_channel,
                                                   req_period, req_one_shot,
                                                   req_now));
      end
   end

   // Response side: a rotating ready pattern, replaced after each full rotation,
   // unless a long hold-off has been requested or stalls are turned off.
   initial begin
      logic [31:0] rx_pattern;
      int          rx_phase;
      rsp_ready  = 1'b0;
      rx_pattern = '1;
      rx_phase   = 0;
      forever begin
         @(negedge clock);
         if (rx_phase == 0) begin
            if ($urandom_range(0, 3) == 0)
               rx_pattern = $urandom & $urandom;
            else
               rx_pattern = $urandom | $urandom;
         end
         rx_phase = (rx_phase + 1) % 32;
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (rx_free) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= rx_pattern[rx_phase];
         end
      end
   end

   // Sends one request; returns at the edge where it is accepted. Valid
   // stays high into the next request unless a gap starts.
   task automatic send_request(
      input logic        kind,
      input logic [2:0]  ch,
      input logic [31:0] per,
      input logic        once,
      input logic [31:0] stamp
   );
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (sender_gapless)
            gap = 0;
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_channel  <= ch;
      req_period   <= per;
      req_one_shot <= once;
      req_now      <= stamp;
      do @(posedge clock); while (!req_ready);
   endtask

   // A poll carries random content in the fields that it does not use.
   task automatic poll_at(input logic [31:0] stamp);
      send_request(REQ_POLL, 3'($urandom_range(0, 7)), $urandom,
                   1'($urandom_range(0, 1)), stamp);
   endtask

   task automatic set_channel(
      input logic [2:0]  ch,
      input logic [31:0] per,
      input logic        once,
      input logic [31:0] stamp
   );
      send_request(REQ_SET, ch, per, once, stamp);
   endtask

   // Time moves forward from origin in small steps, with mostly short
   // periods so that channels fire often; now and then time jumps anywhere.
   task automatic run_timed_traffic(input int count, input logic [31:0] origin);
      logic [31:0] t;
      logic [2:0]  ch;
      logic [31:0] per;
      int          k;
      t = origin;
      for (k = 0; k < count; k++) begin
         t = t + 32'($urandom_range(0, 12));
         if ($urandom_range(0, 4) == 0) begin
            ch = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            if ($urandom_range(0, 9) == 0)
               per = $urandom;
            else if ($urandom_range(0, 7) == 0)
               per = 32'd0;
            else
               per = 32'($urandom_range(1, 40));
            set_channel(ch, per, 1'($urandom_range(0, 1)), t);
         end else if ($urandom_range(0, 32) == 0) begin
            poll_at($urandom);
         end else begin
            poll_at(t);
         end
      end
   endtask

   task automatic test_directed;
      poll_at(32'h0000_0000);
      poll_at(32'hFFFF_FFFF);
      // One-shot channel: fires only when time is strictly past the deadline.
      set_channel(3'd0, 32'd10, 1'b1, 32'd100);
      poll_at(32'd110);
      poll_at(32'd111);
      poll_at(32'd5000);
      // Periodic channel restarts at the poll time when it fires.
      set_channel(3'd1, 32'd5, 1'b0, 32'd0);
      poll_at(32'd6);
      poll_at(32'd11);
      poll_at(32'd12);
      // Channels beyond the last one are ignored.
      set_channel(3'd6, 32'd1, 1'b0, 32'd0);
      set_channel(3'd7, 32'd1, 1'b1, 32'd0);
      poll_at(32'd20);
      // Deadline that wraps past zero.
      set_channel(3'd2, 32'hFFFF_FFFF, 1'b0, 32'd10);
      poll_at(32'd10);
      set_channel(3'd3, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      set_channel(3'd4, 32'd1, 1'b0, 32'd0);
      set_channel(3'd5, 32'd2, 1'b1, 32'd0);
      poll_at(32'hFFFF_FFFF);
      // A zero period disables the channel.
      set_channel(3'd1, 32'd0, 1'b0, 32'd0);
      poll_at(32'h8000_0000);
   endtask

   task automatic test_timed_traffic;
      sender_gapless = 1'b1;
      rx_free        = 1'b1;
      run_timed_traffic(150, 32'h0000_1000);
      sender_gapless = 1'b0;
      rx_free        = 1'b0;
      run_timed_traffic(450, $urandom);
   endtask

   task automatic test_wraparound;
      run_timed_traffic(200, 32'hFFFF_FE00);
   endtask

   task automatic test_random_fields;
      int k;
      for (k = 0; k < 200; k++)
         send_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      $urandom, 1'($urandom_range(0, 1)), $urandom);
   endtask

   task automatic test_backpressure;
      sender_gapless = 1'b1;
      hold_left      = 300;
      run_timed_traffic(120, $urandom);
      sender_gapless = 1'b0;
   endtask

   initial begin
      int i;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_POLL;
      req_channel    = 3'd0;
      req_period     = 32'd0;
      req_one_shot   = 1'b0;
      req_now        = 32'd0;
      error_count    = 0;
      burst_left     = 0;
      sender_gapless = 1'b0;
      rx_free        = 1'b0;
      hold_left      = 0;
      for (i = 0; i < NUM_CHANNELS; i++) begin
         chan_start[i]  = 32'd0;
         chan_period[i] = 32'd0;
         chan_once[i]   = 1'b0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_timed_traffic();
      test_wraparound();
      test_random_fields();
      test_backpressure();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_masks.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
